// File: rtl/arwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package arwt_pkg;

    // Fixed field widths; addresses are kept to ADDR_BITS of the 32-bit port fields
    localparam int ADDR_BITS  = 29;
    localparam int KIND_BITS  = 4;
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 5;

    // Request opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_BAD  = 2'd2;
    localparam logic [1:0] STS_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [3:0]  kind_mask;
        logic [3:0]  slot_index;
        logic [31:0] access_addr;
        logic [6:0]  access_size;
        logic [3:0]  access_kind;
    } arwt_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_out;
        logic [4:0] active_count;
    } arwt_out_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCAN
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic hit;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/arwt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module arwt_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/arwt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module arwt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire arwt_pkg::dp_status_t sts,
    output arwt_pkg::ctrl_cmd_t       cmd,
    output logic                      busy
);

    arwt_pkg::ctrl_state_t state_reg;
    arwt_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arwt_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: scan for check and for add with a nonzero kind mask, single step otherwise
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arwt_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.needs_scan ? arwt_pkg::CS_SCAN : arwt_pkg::CS_EXEC;
                end
            end
            arwt_pkg::CS_EXEC:
            begin
                state_next = arwt_pkg::CS_IDLE;
            end
            arwt_pkg::CS_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    state_next = arwt_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = arwt_pkg::CS_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            arwt_pkg::CS_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            arwt_pkg::CS_EXEC:
            begin
                cmd.commit = 1'b1;
            end
            arwt_pkg::CS_SCAN:
            begin
                cmd.issue  = 1'b1;
                cmd.commit = sts.hit || sts.last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/arwt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module arwt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire arwt_pkg::arwt_in_t  item,
    input  wire arwt_pkg::ctrl_cmd_t cmd,
    output arwt_pkg::dp_status_t     sts,
    output arwt_pkg::arwt_out_t      result,
    output logic                     done
);

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int AW   = arwt_pkg::ADDR_BITS;
    localparam int KB   = arwt_pkg::KIND_BITS;

    // Latched request
    logic [1:0]    op_reg;
    logic [KB-1:0] kinds_in_reg;
    logic [AW-1:0] start_in_reg;
    logic [AW-1:0] end_in_reg;
    logic [3:0]    slot_idx_reg;
    logic [AW-1:0] addr_reg;
    logic [AW:0]   lim_reg;
    logic [KB-1:0] akind_reg;

    // Scan pipeline
    logic [CW-1:0]   scan_cnt_reg;
    logic            q_vld_reg;
    logic [IDXW-1:0] q_pos_reg;
    logic [KB-1:0]   q_kind_reg;

    // Table state
    logic [KB-1:0] kinds_reg [TABLE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result register
    arwt_pkg::arwt_out_t res_reg;
    arwt_pkg::arwt_out_t res_next;
    logic                done_reg;

    logic [2*AW-1:0] rdata;
    logic [AW-1:0]   q_start;
    logic [AW-1:0]   q_end;
    logic            issue_go;
    logic [IDXW-1:0] scan_addr;
    logic            check_hit;
    logic            add_hit;
    logic            hit;
    logic [7:0]      del_ext;
    logic            del_in_range;
    logic [IDXW-1:0] del_pos;
    logic            del_active;
    logic [7:0]      pos_ext;
    logic [7:0]      cnt_ext;
    logic            alloc;
    logic            free;

    // Start and end addresses of each slot
    arwt_ram #(
        .WIDTH (2 * AW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (alloc),
        .waddr (q_pos_reg),
        .wdata ({start_in_reg, end_in_reg}),
        .raddr (scan_addr),
        .rdata (rdata)
    );

    assign q_start = rdata[2*AW-1:AW];
    assign q_end   = rdata[AW-1:0];

    // Issue one slot a cycle while the scan lasts
    assign issue_go  = cmd.issue && (scan_cnt_reg < CW'(TABLE_DEPTH));
    assign scan_addr = scan_cnt_reg[IDXW-1:0];

    // Compare stage
    assign check_hit = (|(q_kind_reg & akind_reg)) &&
                       ((AW+1)'(q_start) < lim_reg) &&
                       (q_end >= addr_reg);
    assign add_hit   = (q_kind_reg == '0);
    assign hit       = q_vld_reg && ((op_reg == arwt_pkg::OP_CHECK) ? check_hit : add_hit);

    // Delete target
    assign del_ext      = 8'(slot_idx_reg);
    assign del_in_range = del_ext < 8'(TABLE_DEPTH);
    assign del_pos      = del_ext[IDXW-1:0];
    assign del_active   = del_in_range && (kinds_reg[del_pos] != '0);

    assign pos_ext = 8'(q_pos_reg);

    // Status to the controller
    always_comb
    begin
        sts.needs_scan = (item.opcode == arwt_pkg::OP_CHECK) ||
                         ((item.opcode == arwt_pkg::OP_ADD) && (item.kind_mask[KB-1:0] != '0));
        sts.hit        = hit;
        sts.last       = q_vld_reg && (q_pos_reg == IDXW'(TABLE_DEPTH - 1));
    end

    // Work out the outcome of the transaction
    always_comb
    begin
        alloc    = 1'b0;
        free     = 1'b0;
        res_next = '0;
        unique case (op_reg)
            arwt_pkg::OP_ADD:
            begin
                if (kinds_in_reg == '0)
                begin
                    res_next.status = arwt_pkg::STS_BAD;
                end
                else if (hit)
                begin
                    res_next.status   = arwt_pkg::STS_OK;
                    res_next.slot_out = pos_ext[3:0];
                    alloc             = cmd.commit;
                end
                else
                begin
                    res_next.status = arwt_pkg::STS_FULL;
                end
            end
            arwt_pkg::OP_DELETE:
            begin
                if (!del_in_range)
                begin
                    res_next.status = arwt_pkg::STS_BAD;
                end
                else
                begin
                    res_next.status = arwt_pkg::STS_OK;
                    free            = cmd.commit && del_active;
                end
            end
            arwt_pkg::OP_CHECK:
            begin
                if (hit)
                begin
                    res_next.status   = arwt_pkg::STS_OK;
                    res_next.slot_out = pos_ext[3:0];
                end
                else
                begin
                    res_next.status = arwt_pkg::STS_MISS;
                end
            end
            default:
            begin
                res_next.status = arwt_pkg::STS_BAD;
            end
        endcase
        count_next = count_reg + CW'(alloc) - CW'(free);
        cnt_ext    = 8'(count_next);
        res_next.active_count = cnt_ext[4:0];
    end

    // Hold the request and the scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= item.opcode;
            kinds_in_reg <= item.kind_mask[KB-1:0];
            start_in_reg <= item.range_start[AW-1:0];
            end_in_reg   <= item.range_end[AW-1:0];
            slot_idx_reg <= item.slot_index;
            addr_reg     <= item.access_addr[AW-1:0];
            lim_reg      <= (AW+1)'(item.access_addr[AW-1:0]) + (AW+1)'(item.access_size);
            akind_reg    <= item.access_kind[KB-1:0];
        end
        if (issue_go)
        begin
            q_pos_reg  <= scan_addr;
            q_kind_reg <= kinds_reg[scan_addr];
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    // Advance the scan, update the table and raise the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            q_vld_reg    <= 1'b0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                kinds_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                q_vld_reg    <= 1'b0;
            end
            else
            begin
                q_vld_reg <= issue_go;
                if (issue_go)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end
            if (alloc)
            begin
                kinds_reg[q_pos_reg] <= kinds_in_reg;
            end
            if (free)
            begin
                kinds_reg[del_pos] <= '0;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            done_reg <= cmd.commit;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// File: rtl/address_range_watchpoint_table.sv
// Channel   Signals                   Transaction taken when
// --------  ------------------------  ------------------------------------
// request   start, busy, item         rising edge with start high, busy low
// result    done, result              rising edge ending the cycle done is high
//
// Delete and rejected requests: no scan; the EXEC state commits the result.
// Add and check scan the slots in order, one per cycle through the entry RAM
// read port and the compare stage, up to the first hit or the last slot; the
// result register then takes the outcome. busy drops as the strobe is raised.
// Reset clears all slots and the active count at once; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per result.
`timescale 1ns / 1ps
`default_nettype none

module address_range_watchpoint_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire arwt_pkg::arwt_in_t item,
    output logic                    done,
    output arwt_pkg::arwt_out_t     result
);

    arwt_pkg::ctrl_cmd_t  cmd;
    arwt_pkg::dp_status_t sts;

    // Sequencing of each transaction
    arwt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Table storage, scan and result
    arwt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire
